// ----- hw/rtl/atbp_pkg.sv -----
package atbp_pkg;

	// default sizes
	localparam int FLOWS_DEF       = 512;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int JOB_FIFO_DEPTH  = 4;

	// field widths
	localparam int MODE_W   = 2;
	localparam int FLOW_W   = 9;
	localparam int SIZE_W   = 14;
	localparam int RND_W    = 16;
	localparam int TAG_W    = 16;
	localparam int ACT_W    = 3;
	localparam int RATE_W   = 40;
	localparam int BUCKET_W = 24;
	localparam int LIMIT_W  = 7;
	localparam int PROB_W   = 16;
	localparam int TICKS_W  = 32;
	localparam int SHIFT_W  = 4;
	localparam int GAIN_W   = 32;
	localparam int TOKEN_W  = 41;
	localparam int BITS_W   = 32;
	localparam int QB_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	// item kinds
	localparam logic [MODE_W-1:0] MODE_PKT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TOKEN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RATE  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	// result actions
	localparam logic [ACT_W-1:0] ACT_BYPASS   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SENT     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_QUEUED   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DROPPED  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RELEASED = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BITS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ASSOC_PROB   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ASSOC_TICKS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_SHIFT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_SHIFT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_GAIN   = 3'd7;

	// register reset values
	localparam logic [RATE_W-1:0]   RST_INITIAL_RATE = 40'd65536000;
	localparam logic [BUCKET_W-1:0] RST_BUCKET_BITS  = 24'd120000;
	localparam logic [LIMIT_W-1:0]  RST_QUEUE_LIMIT  = 7'd64;
	localparam logic [PROB_W-1:0]   RST_ASSOC_PROB   = 16'd8192;
	localparam logic [TICKS_W-1:0]  RST_ASSOC_TICKS  = 32'd625;
	localparam logic [SHIFT_W-1:0]  RST_ETA_SHIFT    = 4'd3;
	localparam logic [SHIFT_W-1:0]  RST_RATIO_SHIFT  = 4'd2;
	localparam logic [GAIN_W-1:0]   RST_QUEUE_GAIN   = 32'd1099512;

	typedef struct packed {
		logic [RATE_W-1:0]   initial_rate;
		logic [BUCKET_W-1:0] bucket_bits;
		logic [LIMIT_W-1:0]  queue_limit;
		logic [PROB_W-1:0]   assoc_prob;
		logic [TICKS_W-1:0]  assoc_ticks;
		logic [SHIFT_W-1:0]  eta_shift;
		logic [SHIFT_W-1:0]  rate_ratio_shift;
		logic [GAIN_W-1:0]   queue_gain;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              assoc;
		logic [TAG_W-1:0]  tag;
		logic [SIZE_W-1:0] size;
		logic [FLOW_W-1:0] flow;
	} job_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [TAG_W-1:0]  tag;
		logic [SIZE_W-1:0] size;
		logic [FLOW_W-1:0] flow;
	} res_t;

	// queue entry: flow, size, tag from high to low
	typedef struct packed {
		logic [FLOW_W-1:0] flow;
		logic [SIZE_W-1:0] size;
		logic [TAG_W-1:0]  tag;
	} qent_t;

endpackage

// ----- hw/rtl/adaptive_token_bucket_pacer.sv -----
// Adaptive token bucket pacer. Items enter on s_axis (tuser = kind: packet, token
// tick, rate tick) and at most one result per item leaves on m_axis. The front end
// takes one beat per clock while the job queue has room and no clearing runs, looks
// the flow up in a FLOWS-entry table with a registered read, forwards its own last
// write and hands the classified item through a four-entry queue to the back end.
// The back end retires a packet once the output is free; a token or rate tick takes
// a second state (registered head read or gain multiply) and holds off new items.
// After reset the flow table is cleared entry by entry with s_axis_tready low;
// configuration writes are taken at any time and must only be issued while idle.
module adaptive_token_bucket_pacer #(
	parameter int FLOWS       = atbp_pkg::FLOWS_DEF,
	parameter int QUEUE_DEPTH = atbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// flow_id[8:0], size_bytes[22:9], echo_mark[23], rand_value[39:24], packet_tag[55:40]
	input  logic [atbp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// mode[1:0]
	input  logic [atbp_pkg::MODE_W-1:0]       s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_tag[15:0], out_size[29:16], out_flow[38:30], zero[39]
	output logic [atbp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// action[2:0]
	output logic [atbp_pkg::ACT_W-1:0]        m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [atbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [atbp_pkg::RATE_W-1:0]       cfg_data
);
	import atbp_pkg::*;

	cfg_t  cfg_q;
	job_t  job_in, job_out;
	res_t  res;
	logic  job_push, job_pop, job_valid, job_room;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{initial_rate: RST_INITIAL_RATE, bucket_bits: RST_BUCKET_BITS,
				queue_limit: RST_QUEUE_LIMIT, assoc_prob: RST_ASSOC_PROB,
				assoc_ticks: RST_ASSOC_TICKS, eta_shift: RST_ETA_SHIFT,
				rate_ratio_shift: RST_RATIO_SHIFT, queue_gain: RST_QUEUE_GAIN};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INITIAL_RATE: cfg_q.initial_rate     <= cfg_data;
				REG_BUCKET_BITS:  cfg_q.bucket_bits      <= cfg_data[BUCKET_W-1:0];
				REG_QUEUE_LIMIT:  cfg_q.queue_limit      <= cfg_data[LIMIT_W-1:0];
				REG_ASSOC_PROB:   cfg_q.assoc_prob       <= cfg_data[PROB_W-1:0];
				REG_ASSOC_TICKS:  cfg_q.assoc_ticks      <= cfg_data[TICKS_W-1:0];
				REG_ETA_SHIFT:    cfg_q.eta_shift        <= cfg_data[SHIFT_W-1:0];
				REG_RATIO_SHIFT:  cfg_q.rate_ratio_shift <= cfg_data[SHIFT_W-1:0];
				REG_QUEUE_GAIN:   cfg_q.queue_gain       <= cfg_data[GAIN_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	atbp_front #(.FLOWS(FLOWS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (s_axis_tuser),
		.in_flow  (s_axis_tdata[8:0]),
		.in_size  (s_axis_tdata[22:9]),
		.in_echo  (s_axis_tdata[23]),
		.in_rnd   (s_axis_tdata[39:24]),
		.in_tag   (s_axis_tdata[55:40]),
		.cfg      (cfg_q),
		.job_room (job_room),
		.job_push (job_push),
		.job      (job_in)
	);

	atbp_fifo #(.DEPTH(JOB_FIFO_DEPTH), .WIDTH($bits(job_t))) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.pop       (job_pop),
		.not_empty (job_valid),
		.room      (job_room),
		.head_data (job_out)
	);

	atbp_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.rate_load     (cfg_we && cfg_index == REG_INITIAL_RATE),
		.rate_load_val (cfg_data),
		.job_valid     (job_valid),
		.job           (job_out),
		.job_pop       (job_pop),
		.res_valid     (m_axis_tvalid),
		.res           (res),
		.res_ready     (m_axis_tready)
	);

	assign m_axis_tdata = {1'b0, res.flow, res.size, res.tag};
	assign m_axis_tuser = res.action;
endmodule

// ----- hw/rtl/atbp_fifo.sv -----
module atbp_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic             room,
	output logic [WIDTH-1:0] head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign not_empty = (cnt_q != '0);
	// space for one beat in flight plus a new one
	assign room      = (cnt_q < CW'(DEPTH - 1));
	assign head_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop)  rd_q <= nxt(rd_q);
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ----- hw/rtl/atbp_front.sv -----
module atbp_front #(
	parameter int FLOWS = atbp_pkg::FLOWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [atbp_pkg::MODE_W-1:0]  in_mode,
	input  logic [atbp_pkg::FLOW_W-1:0]  in_flow,
	input  logic [atbp_pkg::SIZE_W-1:0]  in_size,
	input  logic                         in_echo,
	input  logic [atbp_pkg::RND_W-1:0]   in_rnd,
	input  logic [atbp_pkg::TAG_W-1:0]   in_tag,
	input  atbp_pkg::cfg_t               cfg,
	input  logic                         job_room,
	output logic                         job_push,
	output atbp_pkg::job_t               job
);
	import atbp_pkg::*;

	localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int EW = TICKS_W + 1;

	// flow table: valid bit over mark tick
	logic [EW-1:0] tbl [FLOWS];

	logic          clr_q;
	logic [IW:0]   clr_cnt_q;
	logic          v_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [FLOW_W-1:0] flow_s1;
	logic [SIZE_W-1:0] size_s1;
	logic              echo_s1;
	logic [RND_W-1:0]  rnd_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [IW-1:0]     idx_s1;
	logic [EW-1:0]     rd_s1;
	logic              fwd_v_q;
	logic [IW-1:0]     fwd_idx_q;
	logic [EW-1:0]     fwd_data_q;
	logic [TICKS_W-1:0] tick_q;

	logic              accept;
	logic [IW-1:0]     in_idx;
	logic [EW-1:0]     entry;
	logic              mark_hit, live, assoc, upd;
	logic [TICKS_W-1:0] ent_mark;
	logic [EW-1:0]     upd_data;
	logic              wr_en;
	logic [IW-1:0]     wr_idx;
	logic [EW-1:0]     wr_data;

	// flow_id modulo FLOWS by restoring compare-subtract
	function automatic logic [IW-1:0] flow_mod(input logic [FLOW_W-1:0] f);
		logic [31:0] r;
		r = 32'(f);
		for (int k = FLOW_W - 1; k >= 0; k--) begin
			if (r >= (32'(FLOWS) << k)) r = r - (32'(FLOWS) << k);
		end
		return r[IW-1:0];
	endfunction

	assign in_ready = !clr_q && job_room;
	assign accept   = in_valid && in_ready;
	assign in_idx   = flow_mod(in_flow);

	// lookup result with forwarding of last write
	always_comb begin
		entry    = (fwd_v_q && fwd_idx_q == idx_s1) ? fwd_data_q : rd_s1;
		mark_hit = (mode_s1 == MODE_PKT) && echo_s1 && (rnd_s1 <= cfg.assoc_prob);
		ent_mark = mark_hit ? tick_q : entry[TICKS_W-1:0];
		live     = ((tick_q - ent_mark) < cfg.assoc_ticks);
		assoc    = (mark_hit || entry[EW-1]) && live;
		upd      = v_s1 && (mode_s1 == MODE_PKT) && (mark_hit || (entry[EW-1] && !live));
		// a mark that is already expired leaves the flow unassociated
		upd_data = mark_hit ? {live, tick_q} : {1'b0, entry[TICKS_W-1:0]};
	end

	assign wr_en   = clr_q || upd;
	assign wr_idx  = clr_q ? clr_cnt_q[IW-1:0] : idx_s1;
	assign wr_data = clr_q ? '0 : upd_data;

	// table port
	always_ff @(posedge clk) begin
		if (wr_en) tbl[wr_idx] <= wr_data;
		if (accept) rd_s1 <= tbl[in_idx];
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= in_mode;
			flow_s1 <= in_flow;
			size_s1 <= in_size;
			echo_s1 <= in_echo;
			rnd_s1  <= in_rnd;
			tag_s1  <= in_tag;
			idx_s1  <= in_idx;
		end
		fwd_idx_q  <= idx_s1;
		fwd_data_q <= upd_data;
	end

	// control: clearing pass, stage valid, tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
			fwd_v_q   <= 1'b0;
			tick_q    <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (IW + 1)'(FLOWS - 1)) clr_q <= 1'b0;
			end
			v_s1    <= accept;
			fwd_v_q <= upd;
			if (v_s1 && mode_s1 == MODE_TOKEN) tick_q <= tick_q + 1'b1;
		end
	end

	// hand over to the back end; unused kind is dropped here
	assign job_push   = v_s1 && (mode_s1 != MODE_NONE);
	assign job.mode   = mode_s1;
	assign job.assoc  = assoc;
	assign job.tag    = tag_s1;
	assign job.size   = size_s1;
	assign job.flow   = flow_s1;
endmodule

// ----- hw/rtl/atbp_back.sv -----
module atbp_back #(
	parameter int QUEUE_DEPTH = atbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  atbp_pkg::cfg_t               cfg,
	input  logic                         rate_load,
	input  logic [atbp_pkg::RATE_W-1:0]  rate_load_val,
	input  logic                         job_valid,
	input  atbp_pkg::job_t               job,
	output logic                         job_pop,
	output logic                         res_valid,
	output atbp_pkg::res_t               res,
	input  logic                         res_ready
);
	import atbp_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NEED_W = SIZE_W + 3 + 16;
	localparam int SUM_W  = 50;
	localparam int PROD_W = GAIN_W + QB_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_RATE = 2'd2;

	qent_t             qmem [QUEUE_DEPTH];
	qent_t             qrd_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [TOKEN_W-1:0] token_q;
	logic [RATE_W-1:0]  rate_q;
	logic [BITS_W-1:0]  bits_q;
	logic [QB_W-1:0]    qbits_q;
	logic [QW-1:0]      head_q, tail_q;
	logic [CW-1:0]      cnt_q;
	logic               first_q;
	logic [1:0]         st_q;
	logic               out_valid_q;
	res_t               out_q;

	logic               out_free;
	logic               out_set;
	logic [TOKEN_W-1:0] cap, tok, tsum;
	logic [CW-1:0]      lim;
	logic [SIZE_W+2:0]  pbits, ebits;
	logic [NEED_W-1:0]  pneed, eneed;
	logic [BITS_W:0]    bsum;
	logic [QB_W:0]      qsum;
	logic               do_pkt, do_push, do_rel;
	logic [ACT_W-1:0]   pact;
	logic [SUM_W-1:0]   rsum;
	logic [SHIFT_W:0]   rsh;

	function automatic logic [QW-1:0] nxt(input logic [QW-1:0] p);
		return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_free = !out_valid_q || res_ready;
	assign cap = {1'b0, cfg.bucket_bits, 16'b0};
	assign lim = (cfg.queue_limit > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(cfg.queue_limit);

	// packet decision
	always_comb begin
		tok     = first_q ? cap : token_q;
		pbits   = {job.size, 3'b0};
		pneed   = {pbits, 16'b0};
		bsum    = {1'b0, bits_q} + (BITS_W + 1)'(pbits);
		qsum    = {1'b0, qbits_q} + (QB_W + 1)'(pbits);
		do_pkt  = (st_q == ST_IDLE) && job_valid && (job.mode == MODE_PKT) && out_free;
		do_push = 1'b0;
		if (!job.assoc) begin
			pact = ACT_BYPASS;
		end else if (cnt_q != '0) begin
			pact    = (cnt_q < lim) ? ACT_QUEUED : ACT_DROPPED;
			do_push = (cnt_q < lim);
		end else if (tok >= TOKEN_W'(pneed)) begin
			pact = ACT_SENT;
		end else begin
			pact    = (lim != '0) ? ACT_QUEUED : ACT_DROPPED;
			do_push = (lim != '0);
		end
	end

	// token tick and release
	always_comb begin
		tsum   = token_q + TOKEN_W'(rate_q);
		ebits  = {qrd_s1.size, 3'b0};
		eneed  = {ebits, 16'b0};
		do_rel = (st_q == ST_TICK) && (cnt_q != '0) && (token_q >= TOKEN_W'(eneed));
	end

	// rate update sum
	always_comb begin
		rsh  = {1'b0, cfg.rate_ratio_shift} + {1'b0, cfg.eta_shift};
		rsum = SUM_W'(rate_q) - SUM_W'(rate_q >> cfg.eta_shift)
			+ (SUM_W'({bits_q, 16'b0}) >> rsh)
			+ SUM_W'(prod_s1 >> 16);
	end

	// a new result beat is loaded this cycle
	assign out_set = do_pkt || (do_rel && out_free);

	assign job_pop = (st_q == ST_IDLE) && job_valid && (job.mode != MODE_PKT || out_free);

	// pacing queue and stage registers
	always_ff @(posedge clk) begin
		if (do_pkt && job.assoc && do_push) begin
			qmem[tail_q] <= '{flow: job.flow, size: job.size, tag: job.tag};
		end
		if (st_q == ST_IDLE) qrd_s1 <= qmem[head_q];
		prod_s1 <= PROD_W'(cfg.queue_gain) * PROD_W'(qbits_q);
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (do_pkt) begin
			out_q <= '{action: pact, tag: job.tag, size: job.size, flow: job.flow};
		end else if (do_rel && out_free) begin
			out_q <= '{action: ACT_RELEASED, tag: qrd_s1.tag, size: qrd_s1.size,
				flow: qrd_s1.flow};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q     <= '0;
			rate_q      <= RST_INITIAL_RATE;
			bits_q      <= '0;
			qbits_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			first_q     <= 1'b1;
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && !res_ready);
			if (rate_load) rate_q <= rate_load_val;
			unique case (st_q)
				ST_IDLE: begin
					if (do_pkt) begin
						first_q     <= 1'b0;
						bits_q      <= bsum[BITS_W] ? '1 : bsum[BITS_W-1:0];
						token_q     <= (pact == ACT_SENT) ? tok - TOKEN_W'(pneed) : tok;
						if (do_push) begin
							tail_q  <= nxt(tail_q);
							cnt_q   <= cnt_q + 1'b1;
							qbits_q <= qsum[QB_W] ? '1 : qsum[QB_W-1:0];
						end
					end else if (job_valid && job.mode == MODE_TOKEN) begin
						token_q <= (tsum > cap) ? cap : tsum;
						st_q    <= ST_TICK;
					end else if (job_valid && job.mode == MODE_RATE) begin
						st_q <= ST_RATE;
					end
				end
				ST_TICK: begin
					if (!do_rel) begin
						st_q <= ST_IDLE;
					end else if (out_free) begin
						token_q     <= token_q - TOKEN_W'(eneed);
						head_q      <= nxt(head_q);
						cnt_q       <= cnt_q - 1'b1;
						qbits_q     <= (qbits_q > QB_W'(ebits)) ? qbits_q - QB_W'(ebits) : '0;
						st_q        <= ST_IDLE;
					end
				end
				ST_RATE: begin
					rate_q <= (rsum > SUM_W'({RATE_W{1'b1}})) ? '1 : rsum[RATE_W-1:0];
					bits_q <= '0;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;
endmodule

// ----- hw/rtl/atbp_checker.sv -----
module atbp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [atbp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [atbp_pkg::ACT_W-1:0]      m_axis_tuser
);
	import atbp_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// only defined actions leave the block
	a_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= ACT_RELEASED)
		else $error("undefined action code");

	// pad bit stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[OUT_DATA_W-1])
		else $error("tdata pad bit set");
endmodule

bind adaptive_token_bucket_pacer atbp_checker u_atbp_checker (.*);
